>>> hdl/text_display_keyboard_registers_macros.svh
// Assertion helpers for the display controller
`ifndef TEXT_DISPLAY_KEYBOARD_REGISTERS_MACROS_SVH
`define TEXT_DISPLAY_KEYBOARD_REGISTERS_MACROS_SVH
`ifndef SYNTHESIS
`define TDKR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define TDKR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define TDKR_ASSERT_IMPL(label, clk, rst, ante, cons)
`define TDKR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> hdl/tdkr_pkg.sv
package tdkr_pkg;
   localparam int COLS_DEF           = 80;
   localparam int ROWS_DEF           = 25;
   localparam int KEY_CODES_DEF      = 512;
   localparam int KEY_FIFO_DEPTH_DEF = 16;
   localparam int TEXT_BASE_DEF      = 4096;
   localparam int PIXEL_BASE_DEF     = 8192;

   localparam logic [1:0] CMD_WRITE    = 2'd0;
   localparam logic [1:0] CMD_READ     = 2'd1;
   localparam logic [1:0] CMD_KEY_DOWN = 2'd2;
   localparam logic [1:0] CMD_KEY_UP   = 2'd3;

   localparam logic [13:0] ADDR_COMMAND  = 14'd0;
   localparam logic [13:0] ADDR_CUR_COL  = 14'd1;
   localparam logic [13:0] ADDR_CUR_ROW  = 14'd2;
   localparam logic [13:0] ADDR_TELETYPE = 14'd3;
   localparam logic [13:0] ADDR_KEY_LOW  = 14'd4;
   localparam logic [13:0] ADDR_KEY_HIGH = 14'd5;
   localparam logic [13:0] ADDR_MATRIX   = 14'd16320;

   localparam logic [7:0] OP_TEXT_MODE  = 8'd0;
   localparam logic [7:0] OP_GFX_MODE   = 8'd1;
   localparam logic [7:0] OP_CLEAR_TEXT = 8'd2;
   localparam logic [7:0] OP_HOME       = 8'd3;
   localparam logic [7:0] OP_CLEAR_PIX  = 8'd4;

   localparam logic [7:0] CH_NEWLINE = 8'd10;
   localparam logic [7:0] CH_SPACE   = 8'd32;

   // classified transaction handed from front to back
   typedef struct packed {
      logic [1:0]  command;
      logic [13:0] address;
      logic [7:0]  write_data;
      logic [8:0]  key_code;
   } item_type;
endpackage

>>> hdl/text_display_keyboard_registers.sv
// Channel | Direction | Handshake         | Payload
// req     | in        | req_valid/stall   | command, address, write_data, key_code
// rsp     | out       | rsp_valid/stall   | read_data, graphics_mode, key_dropped
// Plain transactions go through ST_RESP into the result register. Buffer or
// key-matrix reads add ST_READ; key events with a valid code add ST_KEY. Clears
// sweep all COLS*ROWS cells; a teletype scroll reads and writes each text cell.
// Reset is synchronous; buffers are not cleared by it. The key matrix is zeroed by a
// sweep of its (KEY_CODES+7)/8 bytes after reset before the first transaction starts.
// rsp_stall holds the result register; the front queue keeps taking up to two items.
module text_display_keyboard_registers #(
   parameter int COLS           = tdkr_pkg::COLS_DEF,
   parameter int ROWS           = tdkr_pkg::ROWS_DEF,
   parameter int KEY_CODES      = tdkr_pkg::KEY_CODES_DEF,
   parameter int KEY_FIFO_DEPTH = tdkr_pkg::KEY_FIFO_DEPTH_DEF,
   parameter int TEXT_BASE      = tdkr_pkg::TEXT_BASE_DEF,
   parameter int PIXEL_BASE     = tdkr_pkg::PIXEL_BASE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [13:0] req_address,
   input  logic [7:0]  req_write_data,
   input  logic [8:0]  req_key_code,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_graphics_mode,
   output logic        rsp_key_dropped
);
   import tdkr_pkg::*;

   logic     q_valid, q_take;
   item_type q_item;

   tdkr_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_command(req_command), .req_address(req_address),
      .req_write_data(req_write_data), .req_key_code(req_key_code),
      .q_valid(q_valid), .q_item(q_item), .q_take(q_take));

   tdkr_back #(
      .COLS(COLS), .ROWS(ROWS), .KEY_CODES(KEY_CODES),
      .KEY_FIFO_DEPTH(KEY_FIFO_DEPTH), .TEXT_BASE(TEXT_BASE), .PIXEL_BASE(PIXEL_BASE)
   ) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_item(q_item), .q_take(q_take),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_read_data(rsp_read_data),
      .rsp_graphics_mode(rsp_graphics_mode), .rsp_key_dropped(rsp_key_dropped));
endmodule

>>> hdl/tdkr_ram.sv
module tdkr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

>>> hdl/tdkr_front.sv
// Two-entry queue between the request port and the back end.
module tdkr_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_command,
   input  logic [13:0]         req_address,
   input  logic [7:0]          req_write_data,
   input  logic [8:0]          req_key_code,
   output logic                q_valid,
   output tdkr_pkg::item_type  q_item,
   input  logic                q_take
);
   import tdkr_pkg::*;

   item_type   slot_ff [2];
   logic       rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_take;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
      if (push) slot_ff[wr_ptr_ff] <= '{req_command, req_address, req_write_data, req_key_code};
   end
endmodule

>>> hdl/tdkr_back.sv
// Sequencer that carries out one transaction; clears and scrolls sweep the buffers.
module tdkr_back #(
   parameter int COLS           = 80,
   parameter int ROWS           = 25,
   parameter int KEY_CODES      = 512,
   parameter int KEY_FIFO_DEPTH = 16,
   parameter int TEXT_BASE      = 4096,
   parameter int PIXEL_BASE     = 8192
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  tdkr_pkg::item_type q_item,
   output logic               q_take,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_read_data,
   output logic               rsp_graphics_mode,
   output logic               rsp_key_dropped
);
   import tdkr_pkg::*;
`include "text_display_keyboard_registers_macros.svh"

   localparam int SCREEN    = COLS * ROWS;
   localparam int MBYTES    = (KEY_CODES + 7) / 8;
   localparam int SWEEP_TOP = (SCREEN > MBYTES) ? SCREEN : MBYTES;
   localparam int SAW       = $clog2(SWEEP_TOP + 1);
   localparam int AW        = (SCREEN > 1) ? $clog2(SCREEN) : 1;
   localparam int MW        = (MBYTES > 1) ? $clog2(MBYTES) : 1;
   localparam int FW        = (KEY_FIFO_DEPTH > 1) ? $clog2(KEY_FIFO_DEPTH) : 1;
   localparam int FW1       = FW + 1;
   localparam int CW        = $clog2(KEY_FIFO_DEPTH + 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_READ   = 3'd1;
   localparam logic [2:0] ST_CLEAR  = 3'd2;
   localparam logic [2:0] ST_SCR_RD = 3'd3;
   localparam logic [2:0] ST_SCR_WR = 3'd4;
   localparam logic [2:0] ST_RESP   = 3'd5;
   localparam logic [2:0] ST_KEY    = 3'd6;
   localparam logic [2:0] ST_INIT   = 3'd7;

   localparam logic [1:0] SEL_CONST = 2'd0;
   localparam logic [1:0] SEL_TEXT  = 2'd1;
   localparam logic [1:0] SEL_PIX   = 2'd2;
   localparam logic [1:0] SEL_MAT   = 2'd3;

   logic [2:0]     state_ff, state_in;
   item_type       item_ff;
   logic [7:0]     col_ff, row_ff;
   logic           mode_ff;
   logic [8:0]     fifo_ff [KEY_FIFO_DEPTH];
   logic [FW-1:0]  head_ff;
   logic [CW-1:0]  cnt_ff;
   logic [8:0]     last_ff;
   logic [SAW-1:0] sweep_ff;
   logic           clr_text_ff, clr_pix_ff;
   logic [1:0]     rsel_ff;
   logic [7:0]     rconst_ff;
   logic           drop_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rsp_data_ff;
   logic           rsp_mode_ff;
   logic           rsp_drop_ff;

   logic          t_we, p_we;
   logic [AW-1:0] t_wa, t_ra, p_wa, p_ra;
   logic [7:0]    t_wd, p_wd, t_rd, p_rd;
   logic          m_we;
   logic [MW-1:0] m_wa, m_ra;
   logic [7:0]    m_wd, m_rd, kbit;

   tdkr_ram #(.WIDTH(8), .DEPTH(SCREEN)) u_text (
      .clock(clock), .wr_en(t_we), .wr_addr(t_wa), .wr_data(t_wd),
      .rd_addr(t_ra), .rd_data(t_rd));
   tdkr_ram #(.WIDTH(8), .DEPTH(SCREEN)) u_pix (
      .clock(clock), .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd),
      .rd_addr(p_ra), .rd_data(p_rd));
   tdkr_ram #(.WIDTH(8), .DEPTH(MBYTES)) u_matrix (
      .clock(clock), .wr_en(m_we), .wr_addr(m_wa), .wr_data(m_wd),
      .rd_addr(m_ra), .rd_data(m_rd));

   // address decode on the queue head
   logic       in_text, in_pix, in_mat;
   logic [13:0] t_off, p_off, m_off;
   assign t_off   = q_item.address - 14'(TEXT_BASE);
   assign p_off   = q_item.address - 14'(PIXEL_BASE);
   assign m_off   = q_item.address - ADDR_MATRIX;
   assign in_text = (32'(q_item.address) >= TEXT_BASE) &&
                    (32'(q_item.address) < TEXT_BASE + SCREEN);
   assign in_pix  = (32'(q_item.address) >= PIXEL_BASE) &&
                    (32'(q_item.address) < PIXEL_BASE + SCREEN);
   assign in_mat  = (q_item.address >= ADDR_MATRIX) &&
                    (32'(q_item.address) < 32'(ADDR_MATRIX) + MBYTES);

   // teletype position: cursor reduced into the screen; with m constant, only
   // the steps where m << s fits in a byte survive synthesis
   function automatic logic [7:0] mod8(input logic [7:0] v, input logic [7:0] m);
      logic [15:0] r;
      r = {8'd0, v};
      for (int s = 7; s >= 0; s--) begin
         if (r >= ({8'd0, m} << s)) r = r - ({8'd0, m} << s);
      end
      return r[7:0];
   endfunction

   logic [7:0]  tt_col, tt_row;
   logic [15:0] tt_lin;
   logic [8:0]  adv_col, adv_row;
   logic [7:0]  nc, nr;
   logic        need_scroll;
   assign tt_col = mod8(col_ff, 8'(COLS));
   assign tt_row = mod8(row_ff, 8'(ROWS));
   assign tt_lin = 16'(tt_row) * 16'(COLS) + 16'(tt_col);

   always_comb begin
      if (q_item.write_data != CH_NEWLINE) begin
         adv_col = {1'b0, col_ff} + 9'd1;
         adv_row = {1'b0, row_ff};
      end else begin
         adv_col = 9'd0;
         adv_row = {1'b0, row_ff} + 9'd1;
      end
      if (adv_col >= 9'(COLS)) begin
         adv_row = adv_row + 9'd1;
         adv_col = 9'd0;
      end
      need_scroll = (adv_row >= 9'(ROWS));
      if (need_scroll) adv_row = adv_row - 9'd1;
      nc = adv_col[7:0];
      nr = adv_row[7:0];
   end

   logic start;
   assign start  = (state_ff == ST_IDLE) && q_valid;
   assign q_take = start;

   logic [8:0] key;
   logic       key_ok, fifo_full;
   assign key       = q_item.key_code;
   assign key_ok    = (32'(key) < KEY_CODES);
   assign fifo_full = (32'(cnt_ff) >= KEY_FIFO_DEPTH);

   logic [FW1-1:0] tail_sum;
   logic [FW-1:0]  tail, head_next;
   assign tail_sum  = FW1'(head_ff) + FW1'(cnt_ff);
   assign tail      = (32'(tail_sum) >= KEY_FIFO_DEPTH) ?
                      FW'(32'(tail_sum) - KEY_FIFO_DEPTH) : tail_sum[FW-1:0];
   assign head_next = (32'(head_ff) == KEY_FIFO_DEPTH - 1) ? '0 : head_ff + FW'(1);

   assign kbit = 8'd1 << item_ff.key_code[2:0];

   // memory port muxing
   always_comb begin
      t_we = 1'b0; t_wa = t_off[AW-1:0]; t_wd = q_item.write_data;
      p_we = 1'b0; p_wa = p_off[AW-1:0]; p_wd = q_item.write_data;
      t_ra = t_off[AW-1:0]; p_ra = p_off[AW-1:0];
      m_we = 1'b0; m_wa = item_ff.key_code[MW+2:3];
      m_wd = (item_ff.command == CMD_KEY_DOWN) ? (m_rd | kbit) : (m_rd & ~kbit);
      m_ra = (q_item.command == CMD_READ) ? m_off[MW-1:0] : key[MW+2:3];
      if (start && q_item.command == CMD_WRITE) begin
         if (q_item.address == ADDR_TELETYPE && q_item.write_data != CH_NEWLINE) begin
            t_we = 1'b1;
            t_wa = tt_lin[AW-1:0];
         end
         if (in_text && !(q_item.address == ADDR_TELETYPE)) t_we = 1'b1;
         if (in_pix) p_we = 1'b1;
      end
      unique case (state_ff)
         ST_CLEAR: begin
            t_we = clr_text_ff; t_wa = sweep_ff[AW-1:0]; t_wd = CH_SPACE;
            p_we = clr_pix_ff;  p_wa = sweep_ff[AW-1:0]; p_wd = 8'd0;
         end
         ST_SCR_RD: begin
            t_ra = AW'(32'(sweep_ff) + COLS);
         end
         ST_SCR_WR: begin
            t_we = 1'b1; t_wa = sweep_ff[AW-1:0];
            t_wd = (32'(sweep_ff) + COLS < SCREEN) ? t_rd : CH_SPACE;
         end
         ST_KEY: m_we = 1'b1;
         ST_INIT: begin
            m_we = 1'b1; m_wa = sweep_ff[MW-1:0]; m_wd = 8'd0;
         end
         default: ;
      endcase
   end

   // read source select
   logic [1:0] rsel_in_w;
   logic [7:0] rconst_w;
   always_comb begin
      rsel_in_w = SEL_CONST;
      rconst_w  = 8'd0;
      if (q_item.address == ADDR_CUR_COL)      rconst_w = col_ff;
      else if (q_item.address == ADDR_CUR_ROW) rconst_w = row_ff;
      else if (q_item.address == ADDR_KEY_LOW) rconst_w = (cnt_ff != '0) ? fifo_ff[head_ff][7:0] : 8'd0;
      else if (q_item.address == ADDR_KEY_HIGH) rconst_w = {7'd0, last_ff[8]};
      else if (in_text) rsel_in_w = SEL_TEXT;
      else if (in_pix)  rsel_in_w = SEL_PIX;
      else if (in_mat)  rsel_in_w = SEL_MAT;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RESP;
               if (q_item.command == CMD_READ && (rsel_in_w != SEL_CONST)) state_in = ST_READ;
               if ((q_item.command == CMD_KEY_DOWN || q_item.command == CMD_KEY_UP) && key_ok)
                  state_in = ST_KEY;
               if (q_item.command == CMD_WRITE) begin
                  if (q_item.address == ADDR_COMMAND &&
                      (q_item.write_data == OP_CLEAR_TEXT ||
                       q_item.write_data == OP_CLEAR_PIX)) state_in = ST_CLEAR;
                  if (q_item.address == ADDR_TELETYPE && need_scroll) state_in = ST_SCR_RD;
               end
            end
         end
         ST_READ:  state_in = ST_RESP;
         ST_CLEAR: if (32'(sweep_ff) == SCREEN - 1) state_in = ST_RESP;
         ST_SCR_RD: state_in = ST_SCR_WR;
         ST_SCR_WR: state_in = (32'(sweep_ff) == SCREEN - 1) ? ST_RESP : ST_SCR_RD;
         ST_RESP:  if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         ST_KEY:   state_in = ST_RESP;
         ST_INIT:  if (32'(sweep_ff) == MBYTES - 1) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // in ST_RESP the valid bit is set; data loads only while the register is free or being freed
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (state_ff == ST_RESP) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sweep_ff     <= '0;
         col_ff       <= 8'd0;
         row_ff       <= 8'd0;
         mode_ff      <= 1'b0;
         head_ff      <= '0;
         cnt_ff       <= '0;
         last_ff      <= 9'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_CLEAR || state_ff == ST_SCR_WR || state_ff == ST_INIT)
            sweep_ff <= sweep_ff + SAW'(1);
         if (state_ff == ST_READ) begin
            rsel_ff <= SEL_CONST;
            case (rsel_ff)
               SEL_TEXT: rconst_ff <= t_rd;
               SEL_PIX:  rconst_ff <= p_rd;
               default:  rconst_ff <= m_rd;
            endcase
         end
         if (state_ff == ST_RESP && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_data_ff <= rconst_ff;
            rsp_mode_ff <= mode_ff;
            rsp_drop_ff <= drop_ff;
         end
         if (start) begin
            item_ff     <= q_item;
            sweep_ff    <= '0;
            rsel_ff     <= SEL_CONST;
            rconst_ff   <= 8'd0;
            drop_ff     <= 1'b0;
            clr_text_ff <= 1'b0;
            clr_pix_ff  <= 1'b0;
            unique case (q_item.command)
               CMD_WRITE: begin
                  if (q_item.address == ADDR_COMMAND) begin
                     case (q_item.write_data)
                        OP_TEXT_MODE:  mode_ff <= 1'b0;
                        OP_GFX_MODE:   mode_ff <= 1'b1;
                        OP_CLEAR_TEXT: clr_text_ff <= 1'b1;
                        OP_HOME: begin col_ff <= 8'd0; row_ff <= 8'd0; end
                        OP_CLEAR_PIX:  clr_pix_ff <= 1'b1;
                        default: ;
                     endcase
                  end
                  if (q_item.address == ADDR_CUR_COL) col_ff <= q_item.write_data;
                  if (q_item.address == ADDR_CUR_ROW) row_ff <= q_item.write_data;
                  if (q_item.address == ADDR_TELETYPE) begin
                     col_ff <= nc;
                     row_ff <= nr;
                  end
               end
               CMD_READ: begin
                  rsel_ff   <= rsel_in_w;
                  rconst_ff <= rconst_w;
                  if (q_item.address == ADDR_KEY_LOW && cnt_ff != '0) begin
                     last_ff <= fifo_ff[head_ff];
                     head_ff <= head_next;
                     cnt_ff  <= cnt_ff - CW'(1);
                  end
                  if (q_item.address == ADDR_KEY_HIGH) last_ff <= 9'd0;
               end
               CMD_KEY_DOWN: if (key_ok) begin
                  // matrix bit is set in ST_KEY
                  if (fifo_full) drop_ff <= 1'b1;
                  else begin
                     fifo_ff[tail] <= key;
                     cnt_ff <= cnt_ff + CW'(1);
                  end
               end
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_data     = rsp_data_ff;
   assign rsp_graphics_mode = rsp_mode_ff;
   assign rsp_key_dropped   = rsp_drop_ff;

   `TDKR_ASSERT_IMPL(a_take_idle, clock, reset, q_take, state_ff == ST_IDLE)
   `TDKR_ASSERT_IMPL(a_cnt_range, clock, reset, 1'b1, 32'(cnt_ff) <= KEY_FIFO_DEPTH)
   `TDKR_ASSERT_NEXT(a_start_busy, clock, reset, start, state_ff != ST_IDLE)
   `TDKR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
endmodule
